[hdl/ping_pong_message_queue_assert.svh]
// Assertion macros for the ping-pong message queue checker.
// No dependencies; take in with a plain include.
`ifndef PING_PONG_MESSAGE_QUEUE_ASSERT_SVH
`define PING_PONG_MESSAGE_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PPMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PPMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ppmq_pkg.sv]
// Shared types and codes for the ping-pong message queue.
// No dependencies; used by every module of the block.
package ppmq_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned COUNT_W = 7;

    // Request codes
    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_POP    = 2'd2,
        REQ_SWAP   = 2'd3
    } t_req_type;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [DATA_W-1:0] msg_data;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0]  out_data;
        logic [1:0]         status;
        logic [COUNT_W-1:0] swap_size;
        logic [COUNT_W-1:0] write_count;
        logic [COUNT_W-1:0] read_count;
    } t_result;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

[hdl/ping_pong_message_queue.sv]
// Channel   | Handshake          | Payload
// request   | start / busy       | i_req    (ppmq_pkg::t_req)
// result    | o_done (strobe)    | o_result (ppmq_pkg::t_result)
//
// A request is taken when start is high and busy is low. It executes in the
// following cycle (at most one store access) and its result is shown for one
// cycle after that, so a new request may be started while the previous
// result is on the ports. Reset clears pointers, counts and the side select;
// the message store is not cleared.
// The result strobe cannot be stalled.
// Depends on ppmq_pkg, ppmq_ctrl and ppmq_datapath.
module ping_pong_message_queue #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned MSG_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ppmq_pkg::t_req    i_req,
    output logic              o_done,
    output ppmq_pkg::t_result o_result
);

    ppmq_pkg::t_dp_cmd dp_cmd;

    // Sequencer
    ppmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // Store, pointers and result registers
    ppmq_datapath #(
        .DEPTH (DEPTH),
        .MSG_W (MSG_W)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_req    (i_req),
        .o_result (o_result)
    );

endmodule

[hdl/ppmq_ctrl.sv]
// Controller state machine of the ping-pong message queue.
// Depends on ppmq_pkg; drives the datapath commands and the handshake.
module ppmq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output ppmq_pkg::t_dp_cmd o_cmd
);

    ppmq_pkg::t_state r_state;
    ppmq_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppmq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and outputs; a new request may enter while a result is shown
    always_comb begin
        n_state    = r_state;
        o_busy     = 1'b0;
        o_done     = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            ppmq_pkg::S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = ppmq_pkg::S_EXEC;
                end
            end
            ppmq_pkg::S_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
                n_state    = ppmq_pkg::S_DONE;
            end
            ppmq_pkg::S_DONE: begin
                o_done     = 1'b1;
                o_cmd.load = i_start;
                n_state    = i_start ? ppmq_pkg::S_EXEC : ppmq_pkg::S_IDLE;
            end
            default: begin
                n_state = ppmq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hdl/ppmq_datapath.sv]
// Datapath of the ping-pong message queue: message store, pointers, counts.
// Depends on ppmq_pkg; sequenced by ppmq_ctrl through t_dp_cmd.
module ppmq_datapath #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned MSG_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppmq_pkg::t_dp_cmd i_cmd,
    input  ppmq_pkg::t_req    i_req,
    output ppmq_pkg::t_result o_result
);

    localparam int unsigned PTR_W  = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(2 * DEPTH);
    localparam int unsigned EXT_W  = (CNT_W > ppmq_pkg::COUNT_W) ? CNT_W : ppmq_pkg::COUNT_W;

    // Message store: deque A in the lower half, deque B in the upper half
    logic [MSG_W-1:0] mem [0:2*DEPTH-1];

    ppmq_pkg::t_req    r_req;
    logic [MSG_W-1:0]  r_rd_data;
    logic              r_pop_ok;
    logic [1:0]        r_status;
    logic [CNT_W-1:0]  r_swap_size;

    logic [PTR_W-1:0]  r_head [0:1];
    logic [PTR_W-1:0]  r_tail [0:1];
    logic [CNT_W-1:0]  r_cnt  [0:1];
    logic              r_wsel;

    logic [PTR_W-1:0]  n_head [0:1];
    logic [PTR_W-1:0]  n_tail [0:1];
    logic [CNT_W-1:0]  n_cnt  [0:1];
    logic              n_wsel;
    logic              n_pop_ok;
    logic [1:0]        n_status;
    logic [CNT_W-1:0]  n_swap_size;

    logic              w_sel;
    logic              r_sel;
    logic [PTR_W-1:0]  w_head;
    logic [PTR_W-1:0]  w_tail;
    logic [CNT_W-1:0]  w_cnt;
    logic [PTR_W-1:0]  rd_head;
    logic [CNT_W-1:0]  rd_cnt;
    logic [PTR_W-1:0]  w_head_dec;
    logic [PTR_W-1:0]  w_tail_inc;
    logic [PTR_W-1:0]  rd_head_inc;
    logic              w_full;
    logic              rd_empty;
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  wr_ptr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [EXT_W-1:0]  swap_ext;
    logic [EXT_W-1:0]  wcnt_ext;
    logic [EXT_W-1:0]  rcnt_ext;

    // Side selection and per-side views of the pointers
    assign w_sel   = r_wsel;
    assign r_sel   = ~r_wsel;
    assign w_head  = w_sel ? r_head[1] : r_head[0];
    assign w_tail  = w_sel ? r_tail[1] : r_tail[0];
    assign w_cnt   = w_sel ? r_cnt[1]  : r_cnt[0];
    assign rd_head = r_sel ? r_head[1] : r_head[0];
    assign rd_cnt  = r_sel ? r_cnt[1]  : r_cnt[0];

    // Wrapping pointer steps
    assign w_head_dec  = (w_head == '0) ? PTR_W'(DEPTH - 1) : w_head - 1'b1;
    assign w_tail_inc  = (w_tail == PTR_W'(DEPTH - 1)) ? '0 : w_tail + 1'b1;
    assign rd_head_inc = (rd_head == PTR_W'(DEPTH - 1)) ? '0 : rd_head + 1'b1;

    assign w_full   = (w_cnt == CNT_W'(DEPTH));
    assign rd_empty = (rd_cnt == '0);

    // Store addresses
    assign wr_ptr  = (r_req.req_type == ppmq_pkg::REQ_INSERT) ? w_head_dec : w_tail;
    assign wr_addr = w_sel ? ADDR_W'(DEPTH) + ADDR_W'(wr_ptr) : ADDR_W'(wr_ptr);
    assign rd_addr = r_sel ? ADDR_W'(DEPTH) + ADDR_W'(rd_head) : ADDR_W'(rd_head);

    // Request execution: next pointers, counts and result fields
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_wsel      = r_wsel;
        n_pop_ok    = 1'b0;
        n_status    = ppmq_pkg::ST_OK;
        n_swap_size = '0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        unique case (ppmq_pkg::t_req_type'(r_req.req_type))
            ppmq_pkg::REQ_PUSH: begin
                if (w_full) begin
                    n_status = ppmq_pkg::ST_FULL;
                end else begin
                    wr_en         = 1'b1;
                    n_tail[w_sel] = w_tail_inc;
                    n_cnt[w_sel]  = w_cnt + 1'b1;
                end
            end
            ppmq_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_status = ppmq_pkg::ST_FULL;
                end else begin
                    wr_en         = 1'b1;
                    n_head[w_sel] = w_head_dec;
                    n_cnt[w_sel]  = w_cnt + 1'b1;
                end
            end
            ppmq_pkg::REQ_POP: begin
                if (rd_empty) begin
                    n_status = ppmq_pkg::ST_EMPTY;
                end else begin
                    rd_en         = 1'b1;
                    n_pop_ok      = 1'b1;
                    n_head[r_sel] = rd_head_inc;
                    n_cnt[r_sel]  = rd_cnt - 1'b1;
                end
            end
            ppmq_pkg::REQ_SWAP: begin
                n_swap_size = w_cnt;
                if (w_cnt != '0) begin
                    n_wsel = r_sel;
                end
            end
            default: begin
                n_status = ppmq_pkg::ST_OK;
            end
        endcase
    end

    // Request register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_req.msg_data[MSG_W-1:0];
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Pointer, count and side-select state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '{default: '0};
            r_tail   <= '{default: '0};
            r_cnt    <= '{default: '0};
            r_wsel   <= 1'b0;
            r_pop_ok <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cnt    <= n_cnt;
            r_wsel   <= n_wsel;
            r_pop_ok <= n_pop_ok;
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_swap_size <= n_swap_size;
        end
    end

    // Result assembly; counts are shown modulo 128
    assign swap_ext = EXT_W'(r_swap_size);
    assign wcnt_ext = EXT_W'(w_cnt);
    assign rcnt_ext = EXT_W'(rd_cnt);

    assign o_result.out_data    = r_pop_ok ? ppmq_pkg::DATA_W'(r_rd_data) : '0;
    assign o_result.status      = r_status;
    assign o_result.swap_size   = swap_ext[ppmq_pkg::COUNT_W-1:0];
    assign o_result.write_count = wcnt_ext[ppmq_pkg::COUNT_W-1:0];
    assign o_result.read_count  = rcnt_ext[ppmq_pkg::COUNT_W-1:0];

endmodule

[hdl/ppmq_checker.sv]
// Port-level checker for the ping-pong message queue, bound to the top level.
// Depends on ppmq_pkg and ping_pong_message_queue_assert.svh.
`include "ping_pong_message_queue_assert.svh"

module ppmq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input ppmq_pkg::t_result o_result
);

    logic w_accept;
    logic w_failed;
    logic w_quiet;
    logic w_code_ok;

    // Port conditions used by the properties
    assign w_accept  = start && !busy;
    assign w_failed  = o_done && (o_result.status != ppmq_pkg::ST_OK);
    assign w_quiet   = (o_result.out_data == '0) && (o_result.swap_size == '0);
    assign w_code_ok = (o_result.status == ppmq_pkg::ST_OK)
                    || (o_result.status == ppmq_pkg::ST_FULL)
                    || (o_result.status == ppmq_pkg::ST_EMPTY);

    // An accepted request is executing in the next cycle
    `PPMQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy, "accept not followed by busy")

    // Execution always ends in a result strobe
    `PPMQ_ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done && !busy, "busy without result")

    // No data and no swap size on a failed request
    `PPMQ_ASSERT_NOW(a_no_data_on_fail, i_clk, i_rst_n, w_failed, w_quiet, "data on failed request")

    // Only defined status codes are reported
    `PPMQ_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_done, w_code_ok, "undefined status code")

endmodule

bind ping_pong_message_queue ppmq_checker u_ppmq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
